// ----- hw/rtl/cfmp_pkg.sv -----
`default_nettype none
package cfmp_pkg;

   // field limits
   localparam logic [6:0] SECMIN_MAX   = 7'd59;
   localparam logic [6:0] HOUR_MAX     = 7'd23;
   localparam logic [6:0] WEEKDAY_MAX  = 7'd7;
   localparam logic [6:0] MONTHDAY_MAX = 7'd31;
   localparam logic [6:0] MONTH_MAX    = 7'd12;
   localparam logic [6:0] DIGIT_SAT    = 7'd127;
   localparam int         MASK_W       = 60;
   localparam int         IDX_W        = 6;

   // field kinds
   localparam logic [2:0] KIND_SECMIN   = 3'd0;
   localparam logic [2:0] KIND_HOUR     = 3'd1;
   localparam logic [2:0] KIND_WEEKDAY  = 3'd2;
   localparam logic [2:0] KIND_MONTHDAY = 3'd3;
   localparam logic [2:0] KIND_MONTH    = 3'd4;

   // character codes
   localparam logic [7:0] CH_END   = 8'h00;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [2:0] {
      PH_START,
      PH_STAR,
      PH_FIRST,
      PH_DASH,
      PH_SECOND,
      PH_RANGE_STEP,
      PH_STAR_STEP
   } phase_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [7:0] character;
      logic [2:0] field_kind;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic              error;
   } rsp_type;

   // bit walk command: first index, last allowed index, stride
   typedef struct packed {
      logic [IDX_W-1:0] start;
      logic [IDX_W-1:0] last;
      logic [IDX_W-1:0] step;
   } walk_cmd_type;

   typedef struct packed {
      logic active;
      logic last;
   } walk_status_type;

endpackage
`default_nettype wire

// ----- hw/rtl/cfmp_mask_walker.sv -----
`default_nettype none
module cfmp_mask_walker (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     launch,
   input  wire cfmp_pkg::walk_cmd_type   cmd,
   input  wire logic                     clear,
   output cfmp_pkg::walk_status_type     status,
   output logic [cfmp_pkg::MASK_W-1:0]   mask
);

   logic                          active_ff, active_in;
   logic [cfmp_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [cfmp_pkg::IDX_W-1:0]    last_ff, last_in;
   logic [cfmp_pkg::IDX_W-1:0]    step_ff, step_in;
   logic [cfmp_pkg::MASK_W-1:0]   mask_ff, mask_in;
   logic [cfmp_pkg::IDX_W:0]      next_idx;
   logic                          final_bit;

   // shared adder and compare
   assign next_idx  = {1'b0, idx_ff} + {1'b0, step_ff};
   assign final_bit = active_ff && (next_idx > {1'b0, last_ff});

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      last_in   = last_ff;
      step_in   = step_ff;
      mask_in   = mask_ff;
      if (clear) begin
         mask_in = '0;
      end
      if (launch) begin
         active_in = 1'b1;
         idx_in    = cmd.start;
         last_in   = cmd.last;
         step_in   = cmd.step;
      end else if (active_ff) begin
         // set one bit per cycle
         mask_in = mask_ff | (cfmp_pkg::MASK_W'(1) << idx_ff);
         if (final_bit) begin
            active_in = 1'b0;
         end else begin
            idx_in = next_idx[cfmp_pkg::IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         mask_ff   <= '0;
      end else begin
         active_ff <= active_in;
         mask_ff   <= mask_in;
      end
      idx_ff  <= idx_in;
      last_ff <= last_in;
      step_ff <= step_in;
   end

   assign status.active = active_ff;
   assign status.last   = final_bit;
   assign mask          = mask_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/cron_field_mask_parser_unit.sv -----
// cron field mask parser
// an ordinary character request only updates the parse state; a comma or the terminator ends an element
// and then the shared bit walker sets one mask bit per cycle
// the response is registered from the emit state, once the output register is free, after the walk ends
// (or after the terminator if no walk is needed); requests are taken again once the response is loaded
// synchronous active-high reset clears the mask, parse state and response valid
`default_nettype none
module cron_field_mask_parser_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire cfmp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output cfmp_pkg::rsp_type      rsp_data
);

   cfmp_pkg::state_type           state_ff, state_in;
   cfmp_pkg::phase_type           phase_ff, phase_in;
   logic [6:0]                    first_ff, first_in;
   logic [6:0]                    second_ff, second_in;
   logic [6:0]                    digit_ff, digit_in;
   logic                          invalid_ff, invalid_in;
   logic                          term_ff, term_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   cfmp_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic                          accepted;
   logic                          is_digit;
   logic                          is_end;
   logic                          is_comma;
   logic                          ends_element;
   logic [10:0]                   digit_sum;
   logic [6:0]                    digit_next;
   logic                          kind_ok;
   logic [6:0]                    lo;
   logic [6:0]                    hi;
   logic [6:0]                    a_val;
   logic [6:0]                    b_val;
   logic [6:0]                    s_val;
   logic                          elem_ok;
   cfmp_pkg::walk_cmd_type        cmd;
   logic                          launch;
   logic                          load_rsp;
   cfmp_pkg::walk_status_type     walk_status;
   logic [cfmp_pkg::MASK_W-1:0]   walk_mask;

   // character decode
   assign accepted     = req_valid && req_ready;
   assign is_end       = req_data.character == cfmp_pkg::CH_END;
   assign is_comma     = req_data.character == cfmp_pkg::CH_COMMA;
   assign is_digit     = (req_data.character >= cfmp_pkg::CH_ZERO) &&
                         (req_data.character <= cfmp_pkg::CH_NINE);
   assign ends_element = is_end || is_comma;

   // decimal accumulate with saturation
   assign digit_sum  = 11'(digit_ff) * 11'd10 +
                       11'(req_data.character[3:0]);
   assign digit_next = (digit_sum > 11'(cfmp_pkg::DIGIT_SAT)) ?
                       cfmp_pkg::DIGIT_SAT : digit_sum[6:0];

   // field bounds
   always_comb begin
      kind_ok = 1'b1;
      lo      = 7'd0;
      hi      = 7'd0;
      case (req_data.field_kind)
         cfmp_pkg::KIND_SECMIN: begin
            hi = cfmp_pkg::SECMIN_MAX;
         end
         cfmp_pkg::KIND_HOUR: begin
            hi = cfmp_pkg::HOUR_MAX;
         end
         cfmp_pkg::KIND_WEEKDAY: begin
            lo = 7'd1;
            hi = cfmp_pkg::WEEKDAY_MAX;
         end
         cfmp_pkg::KIND_MONTHDAY: begin
            lo = 7'd1;
            hi = cfmp_pkg::MONTHDAY_MAX;
         end
         cfmp_pkg::KIND_MONTH: begin
            lo = 7'd1;
            hi = cfmp_pkg::MONTH_MAX;
         end
         default: begin
            kind_ok = 1'b0;
         end
      endcase
   end

   // element check and walk command
   always_comb begin
      a_val   = first_ff;
      b_val   = digit_ff;
      s_val   = 7'd1;
      elem_ok = 1'b0;
      cmd     = '0;
      case (phase_ff)
         cfmp_pkg::PH_STAR: begin
            elem_ok    = kind_ok;
            cmd.start  = '0;
            cmd.last   = cfmp_pkg::IDX_W'(hi - lo);
            cmd.step   = cfmp_pkg::IDX_W'(1);
         end
         cfmp_pkg::PH_FIRST: begin
            a_val     = digit_ff;
            elem_ok   = kind_ok && (a_val >= lo) && (a_val <= hi);
            cmd.start = cfmp_pkg::IDX_W'(a_val - lo);
            cmd.last  = cfmp_pkg::IDX_W'(a_val - lo);
            cmd.step  = cfmp_pkg::IDX_W'(1);
         end
         cfmp_pkg::PH_SECOND, cfmp_pkg::PH_RANGE_STEP: begin
            if (phase_ff == cfmp_pkg::PH_RANGE_STEP) begin
               b_val = second_ff;
               s_val = digit_ff;
            end
            elem_ok   = kind_ok && (a_val >= lo) && (a_val <= hi) &&
                        (b_val >= lo) && (b_val <= hi) && (a_val <= b_val) &&
                        (s_val >= 7'd1) && (s_val <= hi);
            cmd.start = cfmp_pkg::IDX_W'(a_val - lo);
            cmd.last  = cfmp_pkg::IDX_W'(b_val - lo);
            cmd.step  = cfmp_pkg::IDX_W'(s_val);
         end
         cfmp_pkg::PH_STAR_STEP: begin
            s_val     = digit_ff;
            elem_ok   = kind_ok && (s_val >= 7'd1) && (s_val <= hi);
            cmd.start = cfmp_pkg::IDX_W'(s_val - 7'd1);
            cmd.last  = cfmp_pkg::IDX_W'(hi - lo);
            cmd.step  = cfmp_pkg::IDX_W'(s_val);
         end
         default: begin
            elem_ok = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      case (state_ff)
         cfmp_pkg::S_IDLE: begin
            if (accepted && ends_element && !invalid_ff && elem_ok) begin
               state_in = cfmp_pkg::S_WALK;
               term_in  = is_end;
            end else if (accepted && is_end) begin
               state_in = cfmp_pkg::S_EMIT;
            end
         end
         cfmp_pkg::S_WALK: begin
            if (walk_status.last) begin
               state_in = term_ff ? cfmp_pkg::S_EMIT : cfmp_pkg::S_IDLE;
            end
         end
         cfmp_pkg::S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = cfmp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cfmp_pkg::S_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      launch    = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         cfmp_pkg::S_IDLE: begin
            req_ready = 1'b1;
            launch    = accepted && ends_element && !invalid_ff && elem_ok;
         end
         cfmp_pkg::S_EMIT: begin
            load_rsp = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // parse state update
   always_comb begin
      phase_in   = phase_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      digit_in   = digit_ff;
      invalid_in = invalid_ff;
      if (load_rsp) begin
         invalid_in = 1'b0;
      end
      // terminator returns the element parse to its start, even in a bad string
      if (accepted && is_end) begin
         phase_in  = cfmp_pkg::PH_START;
         first_in  = '0;
         second_in = '0;
         digit_in  = '0;
      end
      if (accepted && !invalid_ff) begin
         if (ends_element) begin
            invalid_in = !elem_ok;
            phase_in   = cfmp_pkg::PH_START;
            first_in   = '0;
            second_in  = '0;
            digit_in   = '0;
         end else begin
            case (phase_ff)
               cfmp_pkg::PH_START: begin
                  if (req_data.character == cfmp_pkg::CH_STAR) begin
                     phase_in = cfmp_pkg::PH_STAR;
                  end else if (is_digit) begin
                     digit_in = digit_next;
                     phase_in = cfmp_pkg::PH_FIRST;
                  end else begin
                     invalid_in = 1'b1;
                  end
               end
               cfmp_pkg::PH_STAR: begin
                  if (req_data.character == cfmp_pkg::CH_SLASH) begin
                     digit_in = '0;
                     phase_in = cfmp_pkg::PH_STAR_STEP;
                  end else begin
                     invalid_in = 1'b1;
                  end
               end
               cfmp_pkg::PH_FIRST: begin
                  if (is_digit) begin
                     digit_in = digit_next;
                  end else if (req_data.character == cfmp_pkg::CH_DASH) begin
                     first_in = digit_ff;
                     digit_in = '0;
                     phase_in = cfmp_pkg::PH_DASH;
                  end else begin
                     invalid_in = 1'b1;
                  end
               end
               cfmp_pkg::PH_DASH: begin
                  if (is_digit) begin
                     digit_in = digit_next;
                     phase_in = cfmp_pkg::PH_SECOND;
                  end else begin
                     invalid_in = 1'b1;
                  end
               end
               cfmp_pkg::PH_SECOND: begin
                  if (is_digit) begin
                     digit_in = digit_next;
                  end else if (req_data.character == cfmp_pkg::CH_SLASH) begin
                     second_in = digit_ff;
                     digit_in  = '0;
                     phase_in  = cfmp_pkg::PH_RANGE_STEP;
                  end else begin
                     invalid_in = 1'b1;
                  end
               end
               cfmp_pkg::PH_RANGE_STEP, cfmp_pkg::PH_STAR_STEP: begin
                  if (is_digit) begin
                     digit_in = digit_next;
                  end else begin
                     invalid_in = 1'b1;
                  end
               end
               default: begin
                  invalid_in = 1'b1;
               end
            endcase
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in      = 1'b1;
         rsp_data_in.mask  = invalid_ff ? '0 : walk_mask;
         rsp_data_in.error = invalid_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cfmp_pkg::S_IDLE;
         phase_ff     <= cfmp_pkg::PH_START;
         first_ff     <= '0;
         second_ff    <= '0;
         digit_ff     <= '0;
         invalid_ff   <= 1'b0;
         term_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         digit_ff     <= digit_in;
         invalid_ff   <= invalid_in;
         term_ff      <= term_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // shared bit walker holds the mask accumulator
   cfmp_mask_walker u_walker (
      .clock  (clock),
      .reset  (reset),
      .launch (launch),
      .cmd    (cmd),
      .clear  (load_rsp),
      .status (walk_status),
      .mask   (walk_mask)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cfmp_pkg::*;

   // field kind that no field uses
   localparam logic [2:0] KIND_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES  = 400;
   localparam int ITEM_TARGET  = 950;

   // field mask predictor and store of expected responses
   class mask_scoreboard;
      rsp_type           expected_q[$];
      int                errors;
      logic [MASK_W-1:0] acc_mask;
      phase_type         phase;
      int                lead_value;
      int                range_end;
      int                digit_value;
      bit                broken;

      function new();
         errors = 0;
         clear_all();
      endfunction

      function void clear_element();
         phase = PH_START;
         lead_value = 0;
         range_end = 0;
         digit_value = 0;
      endfunction

      function void clear_all();
         acc_mask = '0;
         broken = 1'b0;
         clear_element();
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // decimal accumulation, saturating
      function void push_digit(logic [7:0] c);
         int n;
         n = digit_value * 10 + int'(c - CH_ZERO);
         digit_value = (n > int'(DIGIT_SAT)) ? int'(DIGIT_SAT) : n;
      endfunction

      // fold the finished element into the mask or flag the string
      function void close_element(logic [2:0] kind);
         int lo, hi, size, a, b, s, v;
         logic [MASK_W-1:0] bits;
         bit ok;
         bits = '0;
         ok = 1'b1;
         lo = 0;
         hi = 0;
         case (kind)
            KIND_SECMIN:   begin lo = 0; hi = SECMIN_MAX;   end
            KIND_HOUR:     begin lo = 0; hi = HOUR_MAX;     end
            KIND_WEEKDAY:  begin lo = 1; hi = WEEKDAY_MAX;  end
            KIND_MONTHDAY: begin lo = 1; hi = MONTHDAY_MAX; end
            KIND_MONTH:    begin lo = 1; hi = MONTH_MAX;    end
            default:       ok = 1'b0;
         endcase
         size = hi - lo + 1;
         if (ok) begin
            case (phase)
               PH_STAR: begin
                  for (v = 0; v < size; v++) bits[v] = 1'b1;
               end
               PH_FIRST: begin
                  if (digit_value < lo || digit_value > hi) ok = 1'b0;
                  else bits[digit_value - lo] = 1'b1;
               end
               PH_SECOND, PH_RANGE_STEP: begin
                  a = lead_value;
                  b = (phase == PH_SECOND) ? digit_value : range_end;
                  s = (phase == PH_SECOND) ? 1 : digit_value;
                  if (a < lo || a > hi || b < lo || b > hi || a > b || s < 1 || s > hi)
                     ok = 1'b0;
                  else
                     for (v = a; v <= b; v += s) bits[v - lo] = 1'b1;
               end
               PH_STAR_STEP: begin
                  s = digit_value;
                  if (s < 1 || s > hi) ok = 1'b0;
                  else
                     for (v = s - 1; v < size; v += s) bits[v] = 1'b1;
               end
               default: ok = 1'b0;
            endcase
         end
         if (ok) acc_mask = acc_mask | bits;
         else broken = 1'b1;
         clear_element();
      endfunction

      // advance the parse on an accepted request
      function void note_request(req_type r);
         bit is_digit;
         rsp_type e;
         is_digit = (r.character >= CH_ZERO && r.character <= CH_NINE);
         if (r.character == CH_END) begin
            if (!broken) close_element(r.field_kind);
            e.mask = broken ? '0 : acc_mask;
            e.error = broken;
            expected_q.push_back(e);
            clear_all();
            return;
         end
         if (broken) return;
         if (r.character == CH_COMMA) begin
            close_element(r.field_kind);
            return;
         end
         case (phase)
            PH_START: begin
               if (r.character == CH_STAR) phase = PH_STAR;
               else if (is_digit) begin
                  push_digit(r.character);
                  phase = PH_FIRST;
               end else broken = 1'b1;
            end
            PH_STAR: begin
               if (r.character == CH_SLASH) begin
                  digit_value = 0;
                  phase = PH_STAR_STEP;
               end else broken = 1'b1;
            end
            PH_FIRST: begin
               if (is_digit) push_digit(r.character);
               else if (r.character == CH_DASH) begin
                  lead_value = digit_value;
                  digit_value = 0;
                  phase = PH_DASH;
               end else broken = 1'b1;
            end
            PH_DASH: begin
               if (is_digit) begin
                  push_digit(r.character);
                  phase = PH_SECOND;
               end else broken = 1'b1;
            end
            PH_SECOND: begin
               if (is_digit) push_digit(r.character);
               else if (r.character == CH_SLASH) begin
                  range_end = digit_value;
                  digit_value = 0;
                  phase = PH_RANGE_STEP;
               end else broken = 1'b1;
            end
            PH_RANGE_STEP, PH_STAR_STEP: begin
               if (is_digit) push_digit(r.character);
               else broken = 1'b1;
            end
            default: broken = 1'b1;
         endcase
      endfunction

      // compare a response against the oldest expectation
      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual mask %h error %b",
                     $time, got.mask, got.error);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.mask !== e.mask) begin
            $display("%0t: mask mismatch, expected %h actual %h", $time, e.mask, got.mask);
            errors++;
         end
         if (got.error !== e.error) begin
            $display("%0t: error flag mismatch, expected %b actual %b",
                     $time, e.error, got.error);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   mask_scoreboard sb = new();
   logic [7:0] text[$];
   bit  calm = 1'b0;
   int  n_sent = 0;
   int  n_rsp = 0;
   int  cycles = 0;

   cron_field_mask_parser_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // drive one request and wait for it to be taken
   task automatic send_request(logic [7:0] c, logic [2:0] k);
      req_type item;
      int gap;
      item.character = c;
      item.field_kind = k;
      gap = calm ? 0 : int'($urandom_range(0, 19));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
      n_sent++;
      if (n_sent % 40 == 0) calm = ($urandom_range(0, 3) == 0);
   endtask

   // send the buffered text, switching kind at a given position, then the terminator
   task automatic send_text(logic [2:0] kind, logic [2:0] alt, int switch_at);
      for (int i = 0; i < text.size(); i++)
         send_request(text[i], (i >= switch_at) ? alt : kind);
      send_request(CH_END, (switch_at <= text.size()) ? alt : kind);
   endtask

   task automatic put_str(string s);
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
   endtask

   task automatic put_num(int v);
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 3)) text.push_back(CH_ZERO);
      put_str($sformatf("%0d", v));
   endtask

   task automatic directed(string s, logic [2:0] kind);
      text.delete();
      put_str(s);
      send_text(kind, kind, text.size() + 1);
   endtask

   // mostly legal values, sometimes just outside or far out
   function automatic int pick_value(int lo, int hi);
      int r;
      r = $urandom_range(0, 19);
      if (r < 17) return int'($urandom_range(lo, hi));
      if (r == 17) return hi + 1;
      if (r == 18) return (lo > 0) ? lo - 1 : hi + 1;
      return int'($urandom_range(hi + 2, 3000));
   endfunction

   function automatic int pick_step(int hi);
      int r;
      r = $urandom_range(0, 19);
      if (r < 17) return int'($urandom_range(1, hi));
      if (r == 17) return 0;
      if (r == 18) return hi + 1;
      return int'($urandom_range(hi + 2, 500));
   endfunction

   task automatic put_element(int lo, int hi);
      int a, b, t;
      a = pick_value(lo, hi);
      b = pick_value(lo, hi);
      if (a > b && $urandom_range(0, 5) != 0) begin
         t = a;
         a = b;
         b = t;
      end
      case ($urandom_range(0, 4))
         0: text.push_back(CH_STAR);
         1: begin
            text.push_back(CH_STAR);
            text.push_back(CH_SLASH);
            put_num(pick_step(hi));
         end
         2: put_num(a);
         3: begin
            put_num(a);
            text.push_back(CH_DASH);
            put_num(b);
         end
         default: begin
            put_num(a);
            text.push_back(CH_DASH);
            put_num(b);
            text.push_back(CH_SLASH);
            put_num(pick_step(hi));
         end
      endcase
   endtask

   // random field string, sometimes damaged
   task automatic build_field(logic [2:0] kind);
      int lo, hi;
      bit noisy;
      case (kind)
         KIND_HOUR:     begin lo = 0; hi = HOUR_MAX;     end
         KIND_WEEKDAY:  begin lo = 1; hi = WEEKDAY_MAX;  end
         KIND_MONTHDAY: begin lo = 1; hi = MONTHDAY_MAX; end
         KIND_MONTH:    begin lo = 1; hi = MONTH_MAX;    end
         default:       begin lo = 0; hi = SECMIN_MAX;   end
      endcase
      text.delete();
      repeat ($urandom_range(1, 4)) begin
         if (text.size() != 0) text.push_back(CH_COMMA);
         put_element(lo, hi);
      end
      noisy = ($urandom_range(0, 7) == 0);
      if (noisy) begin
         case ($urandom_range(0, 4))
            0: text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(1, 255));
            1: text.insert($urandom_range(0, text.size()), 8'($urandom_range(1, 255)));
            2: text.push_back(CH_COMMA);
            3: text.push_front(CH_COMMA);
            default: begin
               text.delete();
               repeat ($urandom_range(0, 6)) text.push_back(8'($urandom_range(1, 255)));
            end
         endcase
      end
   endtask

   // response side, with one long hold-off to back up the input
   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = calm ? 0 : int'($urandom_range(0, 19));
         if (n_rsp == 15) stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_data);
         n_rsp++;
      end
   end

   // run limit
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // reset, directed strings, random strings, drain
   initial begin
      int sent;
      int r;
      int switch_at;
      logic [2:0] kind;
      logic [2:0] alt;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full star, full range with top step, star step at hour limit
      directed("*", KIND_SECMIN);
      directed("1-7/7", KIND_WEEKDAY);
      directed("*/23", KIND_HOUR);
      // value one past the hour range, empty string
      directed("24", KIND_HOUR);
      directed("", KIND_MONTHDAY);
      // list of two with month extremes
      directed("12,1", KIND_MONTH);
      // high character code and an unknown kind
      text.delete();
      text.push_back(8'hff);
      send_text(KIND_SECMIN, KIND_SECMIN, 2);
      directed("5", KIND_UNUSED);

      sent = 0;
      while (sent < ITEM_TARGET) begin
         r = $urandom_range(0, 19);
         kind = (r == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
         build_field(kind);
         alt = kind;
         switch_at = text.size() + 1;
         // kind changed partway through the string
         if (r == 1) begin
            alt = 3'($urandom_range(0, 4));
            switch_at = $urandom_range(0, text.size());
         end
         send_text(kind, alt, switch_at);
         sent += text.size() + 1;
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
`default_nettype wire

// ----- files.f -----
hw/rtl/cfmp_pkg.sv
hw/rtl/cfmp_mask_walker.sv
hw/rtl/cron_field_mask_parser_unit.sv
test/testbench.sv
